// ===== hw/rtl/isrm_pkg.sv =====
// ----------------------------------------------------------------------------
// isrm_pkg
// Shared constants, request and status codes, and the cell control type for
// the sorted run merger.
// ----------------------------------------------------------------------------
package isrm_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 1024;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned REQ_W       = 2;
   localparam int unsigned INDEX_W     = 10;
   localparam int unsigned COUNT_OUT_W = 11;
   localparam int unsigned STATUS_W    = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   // per-cycle command to a row of cells
   typedef struct packed {
      logic                     shift;
      logic                     wr_en;
      logic signed [DATA_W-1:0] wr_data;
   } chain_ctl_type;

endpackage

// ===== hw/rtl/isrm_req_if.sv =====
// ----------------------------------------------------------------------------
// isrm_req_if
// Request channel: valid/ready handshake with the request payload.
// ----------------------------------------------------------------------------
interface isrm_req_if import isrm_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic [REQ_W-1:0]         req_type;
   logic signed [DATA_W-1:0] value;
   logic                     run_end;
   logic [INDEX_W-1:0]       index;

   modport source (output valid, output req_type, output value, output run_end,
                   output index, input ready);
   modport sink   (input valid, input req_type, input value, input run_end,
                   input index, output ready);

endinterface

// ===== hw/rtl/isrm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// isrm_rsp_if
// Response channel: valid/ready handshake with the read result payload.
// ----------------------------------------------------------------------------
interface isrm_rsp_if import isrm_pkg::*; ();

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] data;
   logic [COUNT_OUT_W-1:0]   element_count;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, output data, output element_count, output status,
                   input ready);
   modport sink   (input valid, input data, input element_count, input status,
                   output ready);

endinterface

// ===== hw/rtl/isrm_cell.sv =====
// ----------------------------------------------------------------------------
// isrm_cell
// One element slot of a chain: loads the write data when addressed, else
// takes its upper neighbor's element on a shift, else holds.
// ----------------------------------------------------------------------------
module isrm_cell import isrm_pkg::*; #(
   parameter int unsigned AW       = 10,
   parameter int unsigned CELL_IDX = 0
) (
   input  logic                     clock,
   input  chain_ctl_type            ctl,
   input  logic [AW-1:0]            wr_pos,
   input  logic signed [DATA_W-1:0] nbr_data,
   output logic signed [DATA_W-1:0] data_ff
);

   localparam logic [AW-1:0] MY_POS = AW'(CELL_IDX);

   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      priority if (ctl.wr_en && (wr_pos == MY_POS)) begin
         data_in = ctl.wr_data;
      end else if (ctl.shift) begin
         data_in = nbr_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ===== hw/rtl/isrm_chain.sv =====
// ----------------------------------------------------------------------------
// isrm_chain
// Row of element cells acting as a queue: the head sits in cell 0, a shift
// moves every element one cell toward the head, a write lands at one slot.
// ----------------------------------------------------------------------------
module isrm_chain import isrm_pkg::*; #(
   parameter int unsigned CAPACITY = CAPACITY_DEFAULT,
   parameter int unsigned AW       = $clog2(CAPACITY)
) (
   input  logic                     clock,
   input  chain_ctl_type            ctl,
   input  logic [AW-1:0]            wr_pos,
   output logic signed [DATA_W-1:0] head
);

   logic signed [DATA_W-1:0] cell_data [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] nbr;
      if (i == CAPACITY - 1) begin : g_last
         assign nbr = cell_data[i];
      end else begin : g_mid
         assign nbr = cell_data[i+1];
      end
      isrm_cell #(
         .AW       (AW),
         .CELL_IDX (i)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .wr_pos   (wr_pos),
         .nbr_data (nbr),
         .data_ff  (cell_data[i])
      );
   end

   assign head = cell_data[0];

endmodule

// ===== hw/rtl/incremental_sorted_run_merger_core.sv =====
// ----------------------------------------------------------------------------
// incremental_sorted_run_merger_core
// Sorted array of signed 32-bit values built by merging sorted runs.
// ----------------------------------------------------------------------------
// Usage: req_ch carries push, read and clear items; rsp_ch returns one item
// per read (data, element count, status). Push and clear give no response.
// The sorted array and the pending run each live in a row of CAPACITY cells;
// only cell 0 of each row is ever read.
// Sequencing: a push without run end or a clear is done in the idle state.
// A push with run end adds one merge step per element of the sorted array
// plus the run, one compare of the two row heads each. A read in range
// rotates the sorted row once around and then loads the response register;
// an out-of-range read loads it directly. One item is in work at a time.
// Reset empties both rows and clears the overflow flag; cell contents are
// not cleared. While rsp_ch is stalled, a finished read holds in the
// response stage and no new item is taken until the response register frees.
// ----------------------------------------------------------------------------
module incremental_sorted_run_merger_core import isrm_pkg::*; #(
   parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   isrm_req_if.sink      req_ch,
   isrm_rsp_if.source    rsp_ch
);

   localparam int unsigned AW   = $clog2(CAPACITY);
   localparam int unsigned CW   = $clog2(CAPACITY + 1);
   localparam int unsigned CMPW = (CW > INDEX_W) ? CW : INDEX_W;
   localparam logic [CW:0] CAP_SUM = (CW + 1)'(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_ROTATE,
      ST_RESP
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            lena_ff, lena_in;
   logic [CW-1:0]            lenb_ff, lenb_in;
   logic [CW-1:0]            a_left_ff, a_left_in;
   logic [CW-1:0]            b_left_ff, b_left_in;
   logic [CW-1:0]            step_ff, step_in;
   logic                     ovf_ff, ovf_in;
   logic [INDEX_W-1:0]       rd_index_ff, rd_index_in;
   logic signed [DATA_W-1:0] rd_data_ff, rd_data_in;
   logic [STATUS_W-1:0]      rd_status_ff, rd_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [COUNT_OUT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   chain_ctl_type            ctl_a, ctl_b;
   logic [AW-1:0]            pos_a, pos_b;
   logic signed [DATA_W-1:0] head_a, head_b;

   logic                     accept;
   logic                     pick_a;
   logic [CMPW-1:0]          idx_ext, lena_ext, step_ext;
   logic [CW:0]              total;

   isrm_chain #(.CAPACITY(CAPACITY), .AW(AW)) u_sorted (
      .clock  (clock),
      .ctl    (ctl_a),
      .wr_pos (pos_a),
      .head   (head_a)
   );

   isrm_chain #(.CAPACITY(CAPACITY), .AW(AW)) u_run (
      .clock  (clock),
      .ctl    (ctl_b),
      .wr_pos (pos_b),
      .head   (head_b)
   );

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign accept               = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.data          = rsp_data_ff;
   assign rsp_ch.element_count = rsp_count_ff;
   assign rsp_ch.status        = rsp_status_ff;

   assign idx_ext  = CMPW'(req_ch.index);
   assign lena_ext = CMPW'(lena_ff);
   assign step_ext = CMPW'(step_ff);
   assign total    = {1'b0, lena_ff} + {1'b0, lenb_ff};
   // new run's element goes first on ties
   assign pick_a   = (a_left_ff != '0) && ((b_left_ff == '0) || (head_a < head_b));

   always_comb begin
      state_in      = state_ff;
      lena_in       = lena_ff;
      lenb_in       = lenb_ff;
      a_left_in     = a_left_ff;
      b_left_in     = b_left_ff;
      step_in       = step_ff;
      ovf_in        = ovf_ff;
      rd_index_in   = rd_index_ff;
      rd_data_in    = rd_data_ff;
      rd_status_in  = rd_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      ctl_a         = '{shift: 1'b0, wr_en: 1'b0, wr_data: head_a};
      ctl_b         = '{shift: 1'b0, wr_en: 1'b0, wr_data: req_ch.value};
      pos_a         = AW'(lena_ff - CW'(1));
      pos_b         = AW'(lenb_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_ch.req_type)
                  REQ_PUSH: begin
                     if (total < CAP_SUM) begin
                        ctl_b.wr_en = 1'b1;
                        lenb_in     = lenb_ff + CW'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                     if (req_ch.run_end && (lenb_in != '0)) begin
                        a_left_in = lena_ff;
                        b_left_in = lenb_in;
                        state_in  = ST_MERGE;
                     end
                  end
                  REQ_READ: begin
                     rd_index_in = req_ch.index;
                     rd_data_in  = '0;
                     step_in     = '0;
                     if (idx_ext < lena_ext) begin
                        rd_status_in = ovf_ff ? STATUS_OVERFLOW : STATUS_OK;
                        state_in     = ST_ROTATE;
                     end else begin
                        rd_status_in = STATUS_RANGE;
                        state_in     = ST_RESP;
                     end
                  end
                  REQ_CLEAR: begin
                     lena_in = '0;
                     lenb_in = '0;
                     ovf_in  = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            if (pick_a) begin
               // pop the old head and append it behind the merged part
               ctl_a.shift   = 1'b1;
               ctl_a.wr_en   = 1'b1;
               ctl_a.wr_data = head_a;
               a_left_in     = a_left_ff - CW'(1);
            end else begin
               ctl_a.wr_en   = 1'b1;
               ctl_a.wr_data = head_b;
               pos_a         = AW'(lena_ff);
               ctl_b.shift   = 1'b1;
               lena_in       = lena_ff + CW'(1);
               lenb_in       = lenb_ff - CW'(1);
               b_left_in     = b_left_ff - CW'(1);
            end
            if ((a_left_in == '0) && (b_left_in == '0)) begin
               state_in = ST_IDLE;
            end
         end
         ST_ROTATE: begin
            ctl_a.shift   = 1'b1;
            ctl_a.wr_en   = 1'b1;
            ctl_a.wr_data = head_a;
            if (step_ext == CMPW'(rd_index_ff)) begin
               rd_data_in = head_a;
            end
            step_in = step_ff + CW'(1);
            if (step_ff == (lena_ff - CW'(1))) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = rd_data_ff;
               rsp_count_in  = COUNT_OUT_W'(lena_ff);
               rsp_status_in = rd_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         lena_ff      <= '0;
         lenb_ff      <= '0;
         a_left_ff    <= '0;
         b_left_ff    <= '0;
         step_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lena_ff      <= lena_in;
         lenb_ff      <= lenb_in;
         a_left_ff    <= a_left_in;
         b_left_ff    <= b_left_in;
         step_ff      <= step_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_index_ff   <= rd_index_in;
      rd_data_ff    <= rd_data_in;
      rd_status_ff  <= rd_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for incremental_sorted_run_merger_core. Drives push, read,
// clear and unused request items, predicts every read response with a local
// model of the sorted array, pending run and overflow flag, and compares
// responses in order. Runs a directed table, then random runs under several
// idle/stall mixes, a long response hold-off, and a fill past capacity.
// ----------------------------------------------------------------------------
module tb_top;
   import isrm_pkg::*;

   localparam int unsigned CAPACITY    = CAPACITY_DEFAULT;
   localparam int          CYCLE_LIMIT = 1_000_000;
   localparam int          HOLD_CYCLES = 400;
   localparam int          PHASE_ITEMS = 150;
   localparam int          DIRECTED_ROWS = 25;

   // request code the block must ignore
   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   typedef logic signed [DATA_W-1:0] elem_t;
   typedef logic [INDEX_W-1:0]       index_t;

   localparam elem_t ELEM_MIN = 32'sh8000_0000;
   localparam elem_t ELEM_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic [REQ_W-1:0] kind;
      elem_t            value;
      logic             run_end;
      index_t           index;
   } req_item_t;

   typedef struct packed {
      elem_t                  data;
      logic [COUNT_OUT_W-1:0] element_count;
      logic [STATUS_W-1:0]    status;
   } rsp_item_t;

   typedef struct packed {
      logic [REQ_W-1:0]       kind;
      elem_t                  value;
      logic                   run_end;
      index_t                 index;
      logic                   typed;
      elem_t                  data;
      logic [COUNT_OUT_W-1:0] element_count;
      logic [STATUS_W-1:0]    status;
   } directed_row_t;

   logic clock;
   logic reset;

   isrm_req_if req_ch ();
   isrm_rsp_if rsp_ch ();

   incremental_sorted_run_merger_core #(
      .CAPACITY (CAPACITY)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // model state
   elem_t     sorted_elems[$];
   elem_t     open_run[$];
   bit        overflow_seen;
   rsp_item_t expected_reads[$];

   int error_count;
   int reads_checked;
   int items_sent;
   int cycle_count;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_asked;
   int hold_served;
   int hold_left;

   // typed rows hold responses that follow directly from the array contents
   directed_row_t directed_rows [DIRECTED_ROWS] = '{
      '{REQ_READ,   0,        0, 0,    1, 0,        0, STATUS_RANGE},
      '{REQ_READ,   0,        0, 1023, 1, 0,        0, STATUS_RANGE},
      '{REQ_PUSH,   ELEM_MIN, 0, 0,    0, 0,        0, STATUS_OK},
      '{REQ_PUSH,   -1,       0, 0,    0, 0,        0, STATUS_OK},
      '{REQ_PUSH,   0,        0, 0,    0, 0,        0, STATUS_OK},
      '{REQ_PUSH,   ELEM_MAX, 1, 1023, 0, 0,        0, STATUS_OK},
      '{REQ_READ,   0,        0, 0,    1, ELEM_MIN, 4, STATUS_OK},
      '{REQ_READ,   0,        0, 3,    1, ELEM_MAX, 4, STATUS_OK},
      '{REQ_READ,   0,        0, 4,    1, 0,        4, STATUS_RANGE},
      '{REQ_PUSH,   -1,       0, 0,    0, 0,        0, STATUS_OK},
      '{REQ_PUSH,   5,        0, 0,    0, 0,        0, STATUS_OK},
      '{REQ_READ,   0,        0, 1,    1, -1,       4, STATUS_OK},
      '{REQ_READ,   0,        0, 4,    1, 0,        4, STATUS_RANGE},
      '{REQ_PUSH,   ELEM_MAX, 1, 0,    0, 0,        0, STATUS_OK},
      '{REQ_READ,   0,        0, 5,    0, 0,        0, STATUS_OK},
      '{REQ_READ,   0,        0, 6,    0, 0,        0, STATUS_OK},
      '{REQ_UNUSED, -1,       1, 1023, 0, 0,        0, STATUS_OK},
      '{REQ_PUSH,   3,        1, 0,    0, 0,        0, STATUS_OK},
      '{REQ_READ,   0,        0, 3,    0, 0,        0, STATUS_OK},
      '{REQ_READ,   0,        0, 8,    0, 0,        0, STATUS_OK},
      '{REQ_CLEAR,  -1,       1, 1023, 0, 0,        0, STATUS_OK},
      '{REQ_READ,   0,        0, 0,    1, 0,        0, STATUS_RANGE},
      '{REQ_PUSH,   7,        1, 0,    0, 0,        0, STATUS_OK},
      '{REQ_READ,   0,        0, 0,    1, 7,        1, STATUS_OK},
      '{REQ_CLEAR,  0,        0, 0,    0, 0,        0, STATUS_OK}
   };

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic bit chance(int pct);
      return $urandom_range(99, 0) < pct;
   endfunction

   function automatic req_item_t make_item(logic [REQ_W-1:0] kind, elem_t value,
                                           logic last, index_t index);
      req_item_t rq;
      rq.kind    = kind;
      rq.value   = value;
      rq.run_end = last;
      rq.index   = index;
      return rq;
   endfunction

   // two-pointer merge; an element of the new run goes first on equal values
   function automatic void merge_open_run();
      elem_t merged[$];
      int    a;
      int    b;
      a = 0;
      b = 0;
      while (a < sorted_elems.size() && b < open_run.size()) begin
         if (sorted_elems[a] < open_run[b]) begin
            merged.push_back(sorted_elems[a]);
            a++;
         end else begin
            merged.push_back(open_run[b]);
            b++;
         end
      end
      while (a < sorted_elems.size()) begin
         merged.push_back(sorted_elems[a]);
         a++;
      end
      while (b < open_run.size()) begin
         merged.push_back(open_run[b]);
         b++;
      end
      sorted_elems = merged;
      open_run.delete();
   endfunction

   function automatic void apply_request(input req_item_t rq, output bit has_rsp,
                                         output rsp_item_t rsp);
      has_rsp = 1'b0;
      rsp     = '0;
      case (rq.kind)
         REQ_PUSH: begin
            if (sorted_elems.size() + open_run.size() < CAPACITY) begin
               open_run.push_back(rq.value);
            end else begin
               overflow_seen = 1'b1;
            end
            if (rq.run_end) begin
               merge_open_run();
            end
         end
         REQ_READ: begin
            has_rsp           = 1'b1;
            rsp.element_count = COUNT_OUT_W'(sorted_elems.size());
            if (int'(rq.index) < sorted_elems.size()) begin
               rsp.data   = sorted_elems[rq.index];
               rsp.status = overflow_seen ? STATUS_OVERFLOW : STATUS_OK;
            end else begin
               rsp.status = STATUS_RANGE;
            end
         end
         REQ_CLEAR: begin
            sorted_elems.delete();
            open_run.delete();
            overflow_seen = 1'b0;
         end
         default: begin
         end
      endcase
   endfunction

   function automatic elem_t pick_value();
      int v;
      case ($urandom_range(9, 0))
         0, 1, 2, 3: begin
            // narrow range, so equal values meet often
            v = $urandom_range(16, 0);
            return elem_t'(v - 8);
         end
         4, 5, 6: return elem_t'($urandom);
         7: begin
            case ($urandom_range(3, 0))
               0:       return ELEM_MIN;
               1:       return ELEM_MAX;
               2:       return elem_t'(0);
               default: return elem_t'(-1);
            endcase
         end
         default: begin
            v = $urandom_range(3, 0);
            return chance(50) ? ELEM_MIN + elem_t'(v) : ELEM_MAX - elem_t'(v);
         end
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      if (error_count < 200) begin
         $display("MISMATCH @%0t: %s", $time, msg);
      end
      error_count++;
   endtask

   task automatic send_request(input req_item_t rq, input bit typed,
                               input rsp_item_t typed_rsp);
      bit        has_rsp;
      rsp_item_t predicted;
      while (chance(send_idle_pct)) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= rq.kind;
      req_ch.value    <= rq.value;
      req_ch.run_end  <= rq.run_end;
      req_ch.index    <= rq.index;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      apply_request(rq, has_rsp, predicted);
      if (has_rsp) begin
         expected_reads.push_back(typed ? typed_rsp : predicted);
      end
      if (rq.kind != REQ_UNUSED) begin
         items_sent++;
      end
   endtask

   task automatic send_run(input int len, input bit close_run);
      elem_t vals[$];
      repeat (len) vals.push_back(pick_value());
      vals.sort();
      foreach (vals[i]) begin
         send_request(make_item(REQ_PUSH, vals[i], close_run && (i == len - 1),
                                index_t'($urandom)), 1'b0, '0);
      end
   endtask

   task automatic send_read(input int idx);
      send_request(make_item(REQ_READ, elem_t'($urandom), $urandom_range(1, 0),
                             index_t'(idx)), 1'b0, '0);
   endtask

   task automatic random_step();
      int roll;
      int pick;
      int held;
      int len;
      roll = $urandom_range(99, 0);
      held = sorted_elems.size();
      if (held + open_run.size() > 48 && roll < 30) begin
         roll = 99;
      end
      if (roll < 50) begin
         send_run($urandom_range(6, 1), 1'b1);
      end else if (roll < 78) begin
         pick = $urandom_range(9, 0);
         if (held > 0 && pick < 7) begin
            send_read($urandom_range(held - 1, 0));
         end else if (pick < 9) begin
            send_read(held + $urandom_range(2, 0));
         end else begin
            send_read($urandom);
         end
      end else if (roll < 90) begin
         // unsorted pushes with random run ends; may leave a run pending
         len = $urandom_range(4, 1);
         repeat (len) begin
            send_request(make_item(REQ_PUSH, pick_value(), $urandom_range(1, 0),
                                   index_t'($urandom)), 1'b0, '0);
         end
      end else if (roll < 95) begin
         send_request(make_item(REQ_UNUSED, elem_t'($urandom), $urandom_range(1, 0),
                                index_t'($urandom)), 1'b0, '0);
      end else begin
         send_request(make_item(REQ_CLEAR, elem_t'($urandom), $urandom_range(1, 0),
                                index_t'($urandom)), 1'b0, '0);
      end
   endtask

   task automatic random_phase(input int send_pct, input int recv_pct);
      int start;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
         random_step();
      end
   endtask

   // fill to capacity, push past it, then merge with the array full
   task automatic fill_past_capacity();
      send_request(make_item(REQ_CLEAR, 0, 1'b0, 0), 1'b0, '0);
      repeat (10) send_run(100, 1'b1);
      send_run(24, 1'b0);
      send_request(make_item(REQ_PUSH, pick_value(), 1'b0, 0), 1'b0, '0);
      send_read(1000);
      send_read(5);
      send_read(999);
      send_request(make_item(REQ_PUSH, pick_value(), 1'b1, 0), 1'b0, '0);
      send_read(1023);
      send_read(0);
      send_read($urandom);
      // run end with nothing collected
      send_request(make_item(REQ_PUSH, pick_value(), 1'b1, 0), 1'b0, '0);
      send_read($urandom);
      send_request(make_item(REQ_CLEAR, 0, 1'b0, 0), 1'b0, '0);
      send_read(0);
      send_run(1, 1'b1);
      send_read(0);
   endtask

   // response ready: random stalls, plus one long hold when asked
   always @(negedge clock) begin
      if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !chance(recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_item_t want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_reads.size() == 0) begin
            report_mismatch($sformatf("read item with none pending, data %0d",
                                      rsp_ch.data));
         end else begin
            want = expected_reads.pop_front();
            if (rsp_ch.data !== want.data) begin
               report_mismatch($sformatf("read %0d: data %0d, want %0d",
                                         reads_checked, rsp_ch.data, want.data));
            end
            if (rsp_ch.element_count !== want.element_count) begin
               report_mismatch($sformatf("read %0d: count %0d, want %0d", reads_checked,
                                         rsp_ch.element_count, want.element_count));
            end
            if (rsp_ch.status !== want.status) begin
               report_mismatch($sformatf("read %0d: status %0d, want %0d",
                                         reads_checked, rsp_ch.status, want.status));
            end
         end
         reads_checked++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("incremental_sorted_run_merger_core regression: fail");
         $finish;
      end
   end

   initial begin
      rsp_item_t row_rsp;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.req_type = REQ_PUSH;
      req_ch.value    = '0;
      req_ch.run_end  = 1'b0;
      req_ch.index    = '0;
      rsp_ch.ready    = 1'b0;
      overflow_seen   = 1'b0;
      error_count     = 0;
      reads_checked   = 0;
      items_sent      = 0;
      cycle_count     = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_asked      = 0;
      hold_served     = 0;
      hold_left       = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row_rsp.data          = directed_rows[i].data;
         row_rsp.element_count = directed_rows[i].element_count;
         row_rsp.status        = directed_rows[i].status;
         send_request(make_item(directed_rows[i].kind, directed_rows[i].value,
                                directed_rows[i].run_end, directed_rows[i].index),
                      directed_rows[i].typed, row_rsp);
      end

      random_phase(0, 0);
      random_phase(72, 0);
      random_phase(0, 72);
      random_phase(27, 27);

      // hold responses off while reads keep coming, so the input stalls
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_run(5, 1'b1);
      hold_asked++;
      repeat (12) send_read($urandom_range(sorted_elems.size(), 0));

      send_idle_pct  = 27;
      recv_stall_pct = 27;
      fill_past_capacity();
      random_phase(0, 0);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_reads.size() != 0) begin
         @(posedge clock);
      end
      repeat (2 * CAPACITY + 16) @(posedge clock);

      if (error_count == 0) begin
         $display("incremental_sorted_run_merger_core regression: pass");
      end else begin
         $display("incremental_sorted_run_merger_core regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/isrm_pkg.sv
hw/rtl/isrm_req_if.sv
hw/rtl/isrm_rsp_if.sv
hw/rtl/isrm_cell.sv
hw/rtl/isrm_chain.sv
hw/rtl/incremental_sorted_run_merger_core.sv
sim/tb_top.sv
